// ===== sv/cabm_pkg.sv =====
package cabm_pkg;

	localparam int OP_W      = 2;
	localparam int LEN_W     = 12;
	localparam int MODE_W    = 2;
	localparam int MCS_W     = 7;
	localparam int CH_W      = 4;
	localparam int PM_W      = 10;
	localparam int BUSY_W    = 32;
	localparam int MS_W      = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam int DIV_N_W   = 32;
	localparam int DIV_D_W   = 16;
	localparam int DIV_CNT_W = 5;

	localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DWELL  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'd1;

	localparam logic [MODE_W-1:0] MODE_HT = 2'd1;

	localparam logic [MS_W-1:0]  DWELL_RESET   = 16'd200;
	localparam logic [LEN_W-1:0] MIN_BYTES     = 12'd14;
	localparam logic [5:0]       HT_PRE_US     = 6'd40;
	localparam logic [5:0]       LEG_PRE_US    = 6'd30;
	localparam logic [6:0]       HT_SCALE      = 7'd80;
	localparam logic [3:0]       LEG_RATE      = 4'd12;
	localparam logic [PM_W-1:0]  PERMILLE_MAX  = 10'd1000;
	localparam logic [CH_W-1:0]  FRAME_CH_MAX  = 4'd13;

	typedef struct packed {
		logic latch;
		logic frame_start;
		logic tick_start;
		logic elapsed_inc;
		logic frame_add;
		logic hop;
		logic read_load;
		logic out_load;
	} cabm_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            frame_ok;
		logic            enable;
		logic            dwell_hit;
		logic            div_done;
		logic            out_free;
	} cabm_sts_t;

	// HT rate in tenths of Mb/s, indexed by low MCS bits
	function automatic logic [9:0] ht_rate(input logic [2:0] sel);
		logic [9:0] r;
		begin
			case (sel)
				3'd0: r = 10'd65;
				3'd1: r = 10'd130;
				3'd2: r = 10'd195;
				3'd3: r = 10'd260;
				3'd4: r = 10'd390;
				3'd5: r = 10'd520;
				3'd6: r = 10'd585;
				default: r = 10'd650;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== sv/cabm_div.sv =====
module cabm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cabm_pkg::DIV_N_W-1:0]  dividend,
	input  logic [cabm_pkg::DIV_D_W-1:0]  divisor,
	output logic                          busy,
	output logic                          done,
	output logic [cabm_pkg::DIV_N_W-1:0]  quotient
);
	import cabm_pkg::*;

	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_D_W:0]     shifted;
	logic [DIV_D_W+1:0]   diff;
	logic                 q_bit;
	logic [DIV_D_W-1:0]   rem_n;

	// restoring, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quo_q[DIV_N_W-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		q_bit   = ~diff[DIV_D_W+1];
		rem_n   = q_bit ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_N_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[DIV_N_W-2:0], q_bit};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/cabm_ctrl.sv =====
module cabm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  cabm_pkg::cabm_sts_t   sts,
	output cabm_pkg::cabm_cmd_t   cmd
);
	import cabm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FRAME_WAIT,
		S_TICK_CHECK,
		S_TICK_WAIT,
		S_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   in_stall_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall_q) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_FRAME: begin
						if (sts.frame_ok) begin
							cmd.frame_start = 1'b1;
							state_d         = S_FRAME_WAIT;
						end else begin
							state_d = S_IDLE;
						end
					end
					OP_TICK: begin
						if (sts.enable) begin
							cmd.elapsed_inc = 1'b1;
							state_d         = S_TICK_CHECK;
						end else begin
							state_d = S_IDLE;
						end
					end
					OP_READ: begin
						cmd.read_load = 1'b1;
						state_d       = S_EMIT;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_FRAME_WAIT: begin
				if (sts.div_done) begin
					cmd.frame_add = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_TICK_CHECK: begin
				if (sts.dwell_hit) begin
					cmd.tick_start = 1'b1;
					state_d        = S_TICK_WAIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_TICK_WAIT: begin
				if (sts.div_done) begin
					cmd.hop = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_stall_q <= (state_d != S_IDLE);
		end
	end

	assign in_stall = in_stall_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken word");

	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.frame_start |=> !cmd.frame_start && !cmd.tick_start)
		else $error("divider restarted back to back");

	a_hop_emits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hop |=> state_q == S_EMIT)
		else $error("hop without report");

endmodule

// ===== sv/cabm_datapath.sv =====
module cabm_datapath #(
	parameter int NUM_CHANNELS = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cabm_pkg::cabm_cmd_t               cmd,
	output cabm_pkg::cabm_sts_t               sts,
	input  logic                              cfg_wr_en,
	input  logic [cabm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cabm_pkg::CFG_W-1:0]        cfg_data,
	input  logic [cabm_pkg::OP_W-1:0]         op,
	input  logic [cabm_pkg::LEN_W-1:0]        frame_length,
	input  logic [cabm_pkg::MODE_W-1:0]       frame_mode,
	input  logic [cabm_pkg::MCS_W-1:0]        frame_mcs,
	input  logic [cabm_pkg::CH_W-1:0]         frame_channel,
	input  logic                              is_misc,
	input  logic [cabm_pkg::CH_W-1:0]         query_channel,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              kind,
	output logic [cabm_pkg::CH_W-1:0]         channel,
	output logic [cabm_pkg::PM_W-1:0]         permille,
	output logic [cabm_pkg::CH_W-1:0]         now_channel
);
	import cabm_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W-1:0] NCH = CH_W'(NUM_CHANNELS);

	// item word
	logic [OP_W-1:0]   op_q;
	logic [LEN_W-1:0]  len_q;
	logic [MODE_W-1:0] mode_q;
	logic [MCS_W-1:0]  mcs_q;
	logic [CH_W-1:0]   fch_q;
	logic              misc_q;
	logic [CH_W-1:0]   qch_q;

	// config and channel state
	logic [MS_W-1:0]   dwell_q;
	logic              enable_q;
	logic [BUSY_W-1:0] busy_q [NUM_CHANNELS];
	logic [PM_W-1:0]   held_q [NUM_CHANNELS];
	logic [CH_W-1:0]   cur_q;
	logic [MS_W-1:0]   elapsed_q;

	// pending result and output word
	logic              res_kind_q;
	logic [CH_W-1:0]   res_ch_q;
	logic [PM_W-1:0]   res_pm_q;
	logic [CH_W-1:0]   res_now_q;
	logic              out_valid_q;
	logic              kind_q;
	logic [CH_W-1:0]   ch_q;
	logic [PM_W-1:0]   pm_q;
	logic [CH_W-1:0]   now_q;

	logic [CH_W-1:0]    fch_m1, cur_m1, qch_m1;
	logic [IDX_W-1:0]   fidx, cidx, qidx, rd_idx;
	logic [BUSY_W-1:0]  busy_rd;
	logic [PM_W-1:0]    held_rd;
	logic               q_ok;
	logic [LEN_W-1:0]   len_eff;
	logic [18:0]        ht_num;
	logic [14:0]        leg_num;
	logic [DIV_N_W-1:0] div_dividend, quo;
	logic [DIV_D_W-1:0] div_divisor;
	logic               div_start, div_busy, div_done;
	logic [16:0]        air;
	logic [BUSY_W:0]    sum;
	logic [BUSY_W-1:0]  busy_sat;
	logic [PM_W-1:0]    pm_sat;
	logic [MS_W-1:0]    limit;
	logic [CH_W-1:0]    cur_next;
	logic               out_free;

	always_comb begin
		fch_m1  = fch_q - 1'b1;
		cur_m1  = cur_q - 1'b1;
		qch_m1  = qch_q - 1'b1;
		fidx    = fch_m1[IDX_W-1:0];
		cidx    = cur_m1[IDX_W-1:0];
		qidx    = qch_m1[IDX_W-1:0];
		rd_idx  = (op_q == OP_FRAME) ? fidx : cidx;
		busy_rd = busy_q[rd_idx];
		q_ok    = (qch_q != '0) && (qch_q <= NCH);
		held_rd = q_ok ? held_q[qidx] : '0;

		len_eff = (len_q < MIN_BYTES) ? MIN_BYTES : len_q;
		ht_num  = 19'(len_eff) * 19'(HT_SCALE);
		leg_num = {len_eff, 3'b000};

		div_start = cmd.frame_start | cmd.tick_start;
		if (cmd.tick_start) begin
			div_dividend = busy_rd;
			div_divisor  = elapsed_q;
		end else if (mode_q == MODE_HT) begin
			div_dividend = DIV_N_W'(ht_num);
			div_divisor  = DIV_D_W'(ht_rate(mcs_q[2:0]));
		end else begin
			div_dividend = DIV_N_W'(leg_num);
			div_divisor  = DIV_D_W'(LEG_RATE);
		end

		air      = 17'(quo[15:0]) + 17'((mode_q == MODE_HT) ? HT_PRE_US : LEG_PRE_US);
		sum      = {1'b0, busy_rd} + (BUSY_W+1)'(air);
		busy_sat = sum[BUSY_W] ? '1 : sum[BUSY_W-1:0];
		pm_sat   = ((|quo[DIV_N_W-1:PM_W]) || (quo[PM_W-1:0] > PERMILLE_MAX))
			? PERMILLE_MAX : quo[PM_W-1:0];

		limit    = (dwell_q == '0) ? MS_W'(1) : dwell_q;
		cur_next = (cur_q >= NCH) ? CH_W'(1) : cur_q + 1'b1;
		out_free = !out_valid_q || !out_stall;

		sts.op        = op_q;
		sts.enable    = enable_q;
		sts.frame_ok  = enable_q && !misc_q && (fch_q != '0) && (fch_q <= FRAME_CH_MAX)
			&& (fch_q <= NCH);
		sts.dwell_hit = (elapsed_q >= limit);
		sts.div_done  = div_done;
		sts.out_free  = out_free;
	end

	cabm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= op;
			len_q  <= frame_length;
			mode_q <= frame_mode;
			mcs_q  <= frame_mcs;
			fch_q  <= frame_channel;
			misc_q <= is_misc;
			qch_q  <= query_channel;
		end
		if (cmd.hop) begin
			res_kind_q <= KIND_REPORT;
			res_ch_q   <= cur_q;
			res_pm_q   <= pm_sat;
			res_now_q  <= cur_next;
		end else if (cmd.read_load) begin
			res_kind_q <= KIND_READ;
			res_ch_q   <= qch_q;
			res_pm_q   <= held_rd;
			res_now_q  <= cur_q;
		end
		if (cmd.out_load) begin
			kind_q <= res_kind_q;
			ch_q   <= res_ch_q;
			pm_q   <= res_pm_q;
			now_q  <= res_now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q     <= DWELL_RESET;
			enable_q    <= 1'b0;
			cur_q       <= CH_W'(1);
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				busy_q[i] <= '0;
				held_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DWELL:  dwell_q  <= cfg_data;
					REG_ENABLE: enable_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.elapsed_inc && (elapsed_q != '1))
				elapsed_q <= elapsed_q + 1'b1;
			if (cmd.frame_add)
				busy_q[fidx] <= busy_sat;
			if (cmd.hop) begin
				held_q[cidx] <= pm_sat;
				busy_q[cidx] <= '0;
				elapsed_q    <= '0;
				cur_q        <= cur_next;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign channel     = ch_q;
	assign permille    = pm_q;
	assign now_channel = now_q;

	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q != '0) && (cur_q <= NCH))
		else $error("observed channel out of range");

	a_hop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hop |=> (elapsed_q == '0) && $changed(cur_q) || (NUM_CHANNELS == 1))
		else $error("hop did not clear dwell");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.frame_add || cmd.hop) |-> div_done && !div_busy)
		else $error("quotient used before divider finished");

endmodule

// ===== sv/channel_airtime_busy_monitor_unit.sv =====
// Per-channel airtime monitor. Frames add an estimated airtime (in us) to the busy
// accumulator of their own channel; millisecond ticks count the dwell on the observed
// channel, and when it expires the block reports busy/elapsed as permille (max 1000),
// holds it, and hops round robin to the next channel. Reads return a held figure.
// One word at a time: frames and expiring ticks wait on the shared radix-2 divider
// (32 quotient bits, one per cycle); reads, non-expiring ticks and dropped words do
// not use it. Results sit in an output register, so the next word is taken while a
// result waits; a second result that is ready before the first is taken holds the
// block in its emit state, and no new word is taken until the first one is.
module channel_airtime_busy_monitor_unit #(
	parameter int NUM_CHANNELS = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [cabm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cabm_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cabm_pkg::OP_W-1:0]         op,
	input  logic [cabm_pkg::LEN_W-1:0]        frame_length,
	input  logic [cabm_pkg::MODE_W-1:0]       frame_mode,
	input  logic [cabm_pkg::MCS_W-1:0]        frame_mcs,
	input  logic [cabm_pkg::CH_W-1:0]         frame_channel,
	input  logic                              is_misc,
	input  logic [cabm_pkg::CH_W-1:0]         query_channel,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              kind,
	output logic [cabm_pkg::CH_W-1:0]         channel,
	output logic [cabm_pkg::PM_W-1:0]         permille,
	output logic [cabm_pkg::CH_W-1:0]         now_channel
);
	import cabm_pkg::*;

	cabm_cmd_t cmd;
	cabm_sts_t sts;

	cabm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cabm_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.frame_length  (frame_length),
		.frame_mode    (frame_mode),
		.frame_mcs     (frame_mcs),
		.frame_channel (frame_channel),
		.is_misc       (is_misc),
		.query_channel (query_channel),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.channel       (channel),
		.permille      (permille),
		.now_channel   (now_channel)
	);

endmodule
